/* design/pru_pkg.sv */
// Shared types and constants for the pixel replicating upscaler.
`default_nettype none

package pru_pkg;

  // Input item kinds.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;
  localparam int CFG_DATA_W = 16;

  // Register field widths.
  localparam int SCALE_W  = 7;
  localparam int SRC_W    = 11;
  localparam int HEIGHT_W = 16;

  // Largest replication factor that is honored.
  localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

  localparam int COLOR_W = 8;
  localparam int PIXEL_W = 3 * COLOR_W;
  localparam int PAD_W   = 2;

  // Depth of the result queue behind the line store read stage.
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 2;

  // Flags that travel with a result through the read stage.
  typedef struct packed {
    logic [PAD_W-1:0] pad_bytes;
    logic             row_end;
    logic             image_end;
    logic             rejected;
  } flags_t;

  // One complete result beat.
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    flags_t             flags;
  } result_t;

endpackage

`default_nettype wire

/* design/pixel_replicating_upscaler_core.sv */
// Top level of the pixel replicating upscaler: line store, sequencing and result queue.
//
// Usage: the item channel (item_valid/item_ready) carries push and pull beats.
// A push (kind 0) writes one source pixel into the line store; once a full
// source row is stored, pulls (kind 1) each return one output pixel on the
// result channel (result_valid/result_ready). Every pixel is repeated
// scale_factor times across and each row scale_factor times down; the last
// pixel of an output row carries row_end and the padding byte count, and the
// last pixel of the image carries image_end. A push while a row is pending
// returns one beat with rejected set; a pull with nothing pending and an
// accepted push return nothing. The cfg channel is always ready and writes
// the register at cfg_index; writes to an unused index are ignored.
// An accepted item's result beat passes the synchronous read of the line
// store and then the result queue stage. Throughput is one item per cycle
// while item_ready is high. A three-beat result queue keeps the item side
// moving while the receiver stalls; item_ready drops only once the queue
// and the read stage hold three results. Reset clears all counters, the
// pending flag, the registers to 1 and the queue; the line store is not
// cleared and needs no clearing pass.
`default_nettype none

module pixel_replicating_upscaler_core #(
  parameter int MAX_SOURCE_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pru_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Item channel.
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic                              kind,
  input  wire logic [pru_pkg::COLOR_W-1:0]       blue,
  input  wire logic [pru_pkg::COLOR_W-1:0]       green,
  input  wire logic [pru_pkg::COLOR_W-1:0]       red,
  // Result channel.
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic [pru_pkg::COLOR_W-1:0]            out_blue,
  output logic [pru_pkg::COLOR_W-1:0]            out_green,
  output logic [pru_pkg::COLOR_W-1:0]            out_red,
  output logic [pru_pkg::PAD_W-1:0]              pad_bytes,
  output logic                                   row_end,
  output logic                                   image_end,
  output logic                                   rejected
);

  localparam int ADDR_W = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int CNT_W  = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int CMP_W  = (CNT_W > pru_pkg::SRC_W) ? CNT_W : pru_pkg::SRC_W;
  localparam int SC_W   = pru_pkg::SCALE_W;
  localparam int HT_W   = pru_pkg::HEIGHT_W;

  // Configuration registers.
  logic [SC_W-1:0]            scale_factor;
  logic [pru_pkg::SRC_W-1:0]  source_width;
  logic [HT_W-1:0]            source_height;

  // Sequencing state.
  logic [CNT_W-1:0] write_column, write_column_next;
  logic [CNT_W-1:0] read_column, read_column_next;
  logic [SC_W-1:0]  across_repeat, across_repeat_next;
  logic [SC_W-1:0]  down_repeat, down_repeat_next;
  logic [HT_W-1:0]  source_row, source_row_next;
  logic             row_pending, row_pending_next;

  // Read stage and result queue.
  logic                          s1_valid;
  pru_pkg::flags_t               s1_flags, flags_next;
  logic [pru_pkg::PIXEL_W-1:0]   pix_q;
  pru_pkg::result_t              queue [pru_pkg::QUEUE_DEPTH];
  logic [pru_pkg::QPTR_W-1:0]    q_wr_ptr, q_rd_ptr;
  logic [pru_pkg::QCNT_W-1:0]    q_count;
  pru_pkg::result_t              q_in, q_out;
  logic                          q_push, q_pop;

  // Line store.
  logic [pru_pkg::PIXEL_W-1:0] line_store [MAX_SOURCE_WIDTH];
  logic [ADDR_W-1:0]           wr_addr, rd_addr;

  logic                        accept, is_push, do_write, do_read, do_reject;
  logic [CNT_W-1:0]            width_eff, wc, rc;
  logic [CMP_W-1:0]            width_ext;
  logic [SC_W-1:0]             scale_eff;
  logic [HT_W-1:0]             height_eff;
  logic [CNT_W:0]              wc_inc, rc_inc;
  logic [SC_W:0]               across_inc, down_inc;
  logic [HT_W:0]               row_inc;
  logic [3:0]                  pad_prod;

  // Configuration writes; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SC_W'(1);
      source_width  <= pru_pkg::SRC_W'(1);
      source_height <= HT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pru_pkg::REG_SCALE_FACTOR:  scale_factor  <= cfg_data[SC_W-1:0];
        pru_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[pru_pkg::SRC_W-1:0];
        pru_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[HT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective register values with out-of-range settings clamped.
  always_comb begin
    width_ext = CMP_W'(source_width);
    if (source_width == '0) begin
      width_ext = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_SOURCE_WIDTH)) begin
      width_ext = CMP_W'(MAX_SOURCE_WIDTH);
    end
    width_eff = width_ext[CNT_W-1:0];

    if (scale_factor == '0) begin
      scale_eff = SC_W'(1);
    end else if (scale_factor > pru_pkg::SCALE_MAX) begin
      scale_eff = pru_pkg::SCALE_MAX;
    end else begin
      scale_eff = scale_factor;
    end

    height_eff = (source_height == '0) ? HT_W'(1) : source_height;
  end

  // Item classification.
  assign accept    = item_valid && item_ready;
  assign is_push   = (kind == pru_pkg::KIND_PUSH);
  assign do_write  = accept && is_push && !row_pending;
  assign do_reject = accept && is_push && row_pending;
  assign do_read   = accept && !is_push && row_pending;

  // Columns are pulled back into range before use.
  assign wc      = (write_column >= width_eff) ? '0 : write_column;
  assign rc      = (read_column >= width_eff) ? width_eff - CNT_W'(1) : read_column;
  assign wc_inc  = {1'b0, wc} + (CNT_W + 1)'(1);
  assign rc_inc  = {1'b0, rc} + (CNT_W + 1)'(1);
  assign across_inc = {1'b0, across_repeat} + (SC_W + 1)'(1);
  assign down_inc   = {1'b0, down_repeat} + (SC_W + 1)'(1);
  assign row_inc    = {1'b0, source_row} + (HT_W + 1)'(1);
  assign wr_addr = wc[ADDR_W-1:0];
  assign rd_addr = rc[ADDR_W-1:0];

  // Row length in bytes is width * scale * 3; its padding to a multiple of
  // four bytes equals (width * scale) modulo four.
  assign pad_prod = {2'b00, width_ext[1:0]} * {2'b00, scale_eff[1:0]};

  // Counter updates for pushes and pulls.
  always_comb begin
    write_column_next  = write_column;
    read_column_next   = read_column;
    across_repeat_next = across_repeat;
    down_repeat_next   = down_repeat;
    source_row_next    = source_row;
    row_pending_next   = row_pending;
    flags_next         = '0;

    if (do_reject) begin
      flags_next.rejected = 1'b1;
    end

    if (do_write) begin
      if (wc_inc >= {1'b0, width_eff}) begin
        write_column_next  = '0;
        row_pending_next   = 1'b1;
        read_column_next   = '0;
        across_repeat_next = '0;
        down_repeat_next   = '0;
      end else begin
        write_column_next = wc_inc[CNT_W-1:0];
      end
    end

    if (do_read) begin
      read_column_next = rc;
      if (across_inc >= {1'b0, scale_eff}) begin
        across_repeat_next = '0;
        if (rc_inc >= {1'b0, width_eff}) begin
          read_column_next     = '0;
          flags_next.row_end   = 1'b1;
          flags_next.pad_bytes = pad_prod[pru_pkg::PAD_W-1:0];
          if (down_inc >= {1'b0, scale_eff}) begin
            down_repeat_next = '0;
            row_pending_next = 1'b0;
            if (row_inc >= {1'b0, height_eff}) begin
              source_row_next      = '0;
              flags_next.image_end = 1'b1;
            end else begin
              source_row_next = row_inc[HT_W-1:0];
            end
          end else begin
            down_repeat_next = down_inc[SC_W-1:0];
          end
        end else begin
          read_column_next = rc_inc[CNT_W-1:0];
        end
      end else begin
        across_repeat_next = across_inc[SC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_column  <= '0;
      read_column   <= '0;
      across_repeat <= '0;
      down_repeat   <= '0;
      source_row    <= '0;
      row_pending   <= 1'b0;
    end else begin
      write_column  <= write_column_next;
      read_column   <= read_column_next;
      across_repeat <= across_repeat_next;
      down_repeat   <= down_repeat_next;
      source_row    <= source_row_next;
      row_pending   <= row_pending_next;
    end
  end

  // Line store. Pushes and pulls never share a cycle, and a row becomes
  // readable only from the cycle after its last write, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (do_write) begin
      line_store[wr_addr] <= {red, green, blue};
    end
    if (do_read) begin
      pix_q <= line_store[rd_addr];
    end
  end

  // Read stage: flags wait alongside the line store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= do_read || do_reject;
    end
  end

  always_ff @(posedge clk) begin
    s1_flags <= flags_next;
  end

  // Result assembly: a rejected beat carries a zero pixel.
  always_comb begin
    q_in.flags = s1_flags;
    if (s1_flags.rejected) begin
      q_in.blue  = '0;
      q_in.green = '0;
      q_in.red   = '0;
    end else begin
      q_in.red   = pix_q[3*pru_pkg::COLOR_W-1:2*pru_pkg::COLOR_W];
      q_in.green = pix_q[2*pru_pkg::COLOR_W-1:pru_pkg::COLOR_W];
      q_in.blue  = pix_q[pru_pkg::COLOR_W-1:0];
    end
  end

  // Result queue control; ready counts the beat still in the read stage.
  assign q_push       = s1_valid;
  assign result_valid = (q_count != '0);
  assign q_pop        = result_valid && result_ready;
  assign item_ready   = ({1'b0, q_count} + {2'b00, s1_valid}) <
                        (pru_pkg::QCNT_W + 1)'(pru_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr <= (q_wr_ptr == pru_pkg::QPTR_W'(pru_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : q_wr_ptr + pru_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        q_rd_ptr <= (q_rd_ptr == pru_pkg::QPTR_W'(pru_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : q_rd_ptr + pru_pkg::QPTR_W'(1);
      end
      if (q_push && !q_pop) begin
        q_count <= q_count + pru_pkg::QCNT_W'(1);
      end else if (!q_push && q_pop) begin
        q_count <= q_count - pru_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      queue[q_wr_ptr] <= q_in;
    end
  end

  // Head of the queue drives the result ports.
  assign q_out     = queue[q_rd_ptr];
  assign out_blue  = q_out.blue;
  assign out_green = q_out.green;
  assign out_red   = q_out.red;
  assign pad_bytes = q_out.flags.pad_bytes;
  assign row_end   = q_out.flags.row_end;
  assign image_end = q_out.flags.image_end;
  assign rejected  = q_out.flags.rejected;

endmodule

`default_nettype wire

/* design/pru_checker.sv */
// Port-level checker for the pixel replicating upscaler, with its bind.
`default_nettype none

module pru_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [pru_pkg::COLOR_W-1:0] out_blue,
  input wire logic [pru_pkg::COLOR_W-1:0] out_green,
  input wire logic [pru_pkg::COLOR_W-1:0] out_red,
  input wire logic [pru_pkg::PAD_W-1:0]   pad_bytes,
  input wire logic                        row_end,
  input wire logic                        image_end,
  input wire logic                        rejected
);

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat offered right after reset");

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_blue) &&
      $stable(out_green) && $stable(out_red) && $stable(pad_bytes) &&
      $stable(row_end) && $stable(image_end) && $stable(rejected))
    else $error("stalled result beat changed");

  // A rejected push carries nothing else.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && rejected |-> out_blue == '0 && out_green == '0 &&
      out_red == '0 && pad_bytes == '0 && !row_end && !image_end)
    else $error("rejected beat carries pixel data or flags");

  // The image ends only at the end of an output row.
  a_image_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && image_end |-> row_end)
    else $error("image_end without row_end");

  // Padding appears only at the end of an output row.
  a_pad_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && pad_bytes != '0 |-> row_end)
    else $error("padding outside a row end");

endmodule

bind pixel_replicating_upscaler_core pru_checker u_pru_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .out_blue     (out_blue),
  .out_green    (out_green),
  .out_red      (out_red),
  .pad_bytes    (pad_bytes),
  .row_end      (row_end),
  .image_end    (image_end),
  .rejected     (rejected)
);

`default_nettype wire
